// ===== design/psba_pkg.sv =====
`timescale 1ns / 1ps
package psba_pkg;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NO_MEM    = 2'd1;
	localparam logic [1:0] STAT_OUTSIDE   = 2'd2;
	localparam logic [1:0] STAT_TOO_LARGE = 2'd3;

	localparam logic CFG_REGION_BASE  = 1'b0;
	localparam logic CFG_REGION_PAGES = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_PG, S_F_CHK, S_A_CHK, S_SRCH,
		S_U0, S_U1, S_U2, S_P0, S_P1, S_DONE
	} state_t;

	// what the current unlink or push sequence belongs to
	typedef enum logic [1:0] {M_POP, M_REL, M_CARVE, M_FREE} mode_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [11:0] block_bytes;
		logic [31:0] block_address;
	} result_t;

endpackage

// ===== design/psba_ram.sv =====
`timescale 1ns / 1ps
module psba_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 8192,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/psba_ctrl.sv =====
`timescale 1ns / 1ps
module psba_ctrl import psba_pkg::*; #(
	parameter int NUM_PAGES       = 16,
	parameter int PAGE_BYTES      = 4096,
	parameter int MIN_BLOCK_BYTES = 8,
	parameter int MAX_BLOCK_BYTES = 2048,
	localparam int SLOTS = PAGE_BYTES / MIN_BLOCK_BYTES,
	localparam int NSLOT = NUM_PAGES * SLOTS,
	localparam int LW    = $clog2(NSLOT + 1),
	localparam int SAW   = (NSLOT > 1) ? $clog2(NSLOT) : 1,
	localparam int NPW   = $clog2(NUM_PAGES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            reinit,
	input  logic [NPW-1:0]  cfg_pages,
	input  logic [31:0]     region_base,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      in_opcode,
	input  logic [11:0]     in_req_size,
	input  logic [31:0]     in_address,
	output logic            res_valid,
	input  logic            res_ready,
	output result_t         res,
	output logic [SAW-1:0]  raddr,
	input  logic [LW-1:0]   nx_rdata,
	input  logic [LW-1:0]   pv_rdata,
	output logic            nx_we,
	output logic [SAW-1:0]  nx_waddr,
	output logic [LW-1:0]   nx_wdata,
	output logic            pv_we,
	output logic [SAW-1:0]  pv_waddr,
	output logic [LW-1:0]   pv_wdata
);
	function automatic int ncls_f();
		int v;
		int n;
		v = MIN_BLOCK_BYTES;
		n = 1;
		while (v < MAX_BLOCK_BYTES && n < 32) begin
			v = v << 1;
			n++;
		end
		return n;
	endfunction

	localparam int NCLS = ncls_f();
	localparam int CLW  = (NCLS > 1) ? $clog2(NCLS) : 1;
	localparam int PGW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int PBW  = $clog2(PAGE_BYTES);
	localparam int MBW  = $clog2(MIN_BLOCK_BYTES);
	localparam int SLW  = PBW - MBW;
	localparam int PCW  = $clog2(SLOTS + 1);
	localparam logic [LW-1:0] LNULL = LW'(NSLOT);

	state_t state_q, state_d;
	mode_t  mode_q;

	logic [1:0]      op_q;
	logic [11:0]     req_q;
	logic [31:0]     addr_q;
	logic            inside_q;
	logic [CLW-1:0]  cls_q;
	logic [PGW-1:0]  pg_q;
	logic [LW-1:0]   slot_q;
	logic [LW-1:0]   t_q;
	logic [PCW-1:0]  iter_q;
	result_t         res_q;

	logic [LW-1:0]   head_q [NCLS];
	logic [LW-1:0]   tail_q [NCLS];
	logic            used_q [NUM_PAGES];
	logic [CLW-1:0]  pcls_q [NUM_PAGES];
	logic [PCW-1:0]  pfc_q  [NUM_PAGES];
	logic [PGW-1:0]  fpq_q  [NUM_PAGES];
	logic [PGW-1:0]  fq_hd_q;
	logic [NPW-1:0]  fq_cnt_q;

	logic [31:0]     offset;
	logic            in_rgn;
	logic [PGW-1:0]  pg_calc;
	logic            too_big;
	logic [CLW-1:0]  c_calc;
	logic [LW-1:0]   hd_sel;
	logic            hd_nn;
	logic [CLW-1:0]  cls_pg;
	logic [PCW-1:0]  pfc_pg;
	logic [PCW-1:0]  total;
	logic [LW-1:0]   step;
	logic            last_blk;
	logic            listed;
	logic            free_ok;
	logic            new_full;
	logic            more_cls;
	logic [PBW-1:0]  off_in;
	logic [PBW-1:0]  off_al;
	logic [LW-1:0]   slot_f;
	logic [PGW-1:0]  np;
	logic [NPW:0]    tl_sum;
	logic [PGW-1:0]  tl_idx;

	always_comb begin
		offset  = addr_q - region_base;
		in_rgn  = {1'b0, offset} < (33'(cfg_pages) << PBW);
		pg_calc = PGW'(offset >> PBW);
		too_big = 32'(req_q) > 32'(MAX_BLOCK_BYTES);
		c_calc  = '0;
		for (int k = 0; k < NCLS - 1; k++) begin
			if ((32'(MIN_BLOCK_BYTES) << k) < 32'(req_q)) begin
				c_calc = c_calc + CLW'(1);
			end
		end
		hd_sel   = head_q[cls_q];
		hd_nn    = hd_sel != LNULL;
		cls_pg   = pcls_q[pg_q];
		pfc_pg   = pfc_q[pg_q];
		total    = PCW'(32'(SLOTS) >> cls_q);
		step     = LW'(1) << cls_q;
		last_blk = ((PCW+1)'(iter_q) + 1'b1) == (PCW+1)'(total);
		listed   = (pv_rdata != LNULL) || (hd_sel == slot_q);
		free_ok  = !listed && (pfc_pg < total);
		new_full = ((PCW+1)'(pfc_pg) + 1'b1) == (PCW+1)'(total);
		more_cls = (32'(cls_q) + 32'd1) < 32'(NCLS);
		off_in   = offset[PBW-1:0] >> MBW;
		off_al   = (off_in >> cls_pg) << cls_pg;
		slot_f   = (LW'(pg_q) << SLW) | LW'(off_al);
		np       = fpq_q[fq_hd_q];
		tl_sum   = (NPW+1)'(fq_hd_q) + (NPW+1)'(fq_cnt_q);
		if (tl_sum >= (NPW+1)'(NUM_PAGES)) begin
			tl_sum = tl_sum - (NPW+1)'(NUM_PAGES);
		end
		tl_idx = PGW'(tl_sum);
	end

	// next state and memory port control
	always_comb begin
		state_d   = state_q;
		in_ready  = state_q == S_IDLE;
		res_valid = state_q == S_DONE;
		res       = res_q;
		raddr     = (state_q == S_PG) ? slot_f[SAW-1:0] : slot_q[SAW-1:0];
		nx_we     = 1'b0;
		nx_waddr  = slot_q[SAW-1:0];
		nx_wdata  = LNULL;
		pv_we     = 1'b0;
		pv_waddr  = slot_q[SAW-1:0];
		pv_wdata  = LNULL;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DEC;
			end
			S_DEC: begin
				case (op_q)
					OP_ALLOC: state_d = too_big ? S_DONE : S_A_CHK;
					OP_FREE, OP_QUERY: state_d = S_PG;
					default: state_d = S_DONE;
				endcase
			end
			S_PG: begin
				if (!inside_q || op_q == OP_QUERY || !used_q[pg_q]) state_d = S_DONE;
				else state_d = S_F_CHK;
			end
			S_F_CHK: state_d = free_ok ? S_P0 : S_DONE;
			S_A_CHK: begin
				if (hd_nn) state_d = S_U0;
				else if (fq_cnt_q != '0) state_d = S_P0;
				else if (more_cls) state_d = S_SRCH;
				else state_d = S_DONE;
			end
			S_SRCH: begin
				if (hd_nn) state_d = S_U0;
				else if (!more_cls) state_d = S_DONE;
			end
			S_U0: state_d = S_U1;
			S_U1: begin
				state_d = S_U2;
				if (pv_rdata != LNULL) begin
					nx_we    = 1'b1;
					nx_waddr = pv_rdata[SAW-1:0];
					nx_wdata = nx_rdata;
				end
				if (nx_rdata != LNULL) begin
					pv_we    = 1'b1;
					pv_waddr = nx_rdata[SAW-1:0];
					pv_wdata = pv_rdata;
				end
			end
			S_U2: begin
				nx_we = 1'b1;
				pv_we = 1'b1;
				if (mode_q == M_POP || last_blk) state_d = S_DONE;
				else state_d = S_U0;
			end
			S_P0: begin
				nx_we    = 1'b1;
				pv_we    = 1'b1;
				pv_wdata = tail_q[cls_q];
				state_d  = S_P1;
			end
			S_P1: begin
				if (t_q != LNULL) begin
					nx_we    = 1'b1;
					nx_waddr = t_q[SAW-1:0];
					nx_wdata = slot_q;
				end
				if (mode_q == M_CARVE) state_d = last_blk ? S_A_CHK : S_P0;
				else state_d = new_full ? S_U0 : S_DONE;
			end
			S_DONE: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_POP;
			op_q     <= OP_ALLOC;
			req_q    <= '0;
			addr_q   <= '0;
			inside_q <= 1'b0;
			cls_q    <= '0;
			pg_q     <= '0;
			slot_q   <= '0;
			t_q      <= '0;
			iter_q   <= '0;
			res_q    <= '0;
			for (int i = 0; i < NCLS; i++) begin
				head_q[i] <= LNULL;
				tail_q[i] <= LNULL;
			end
			for (int i = 0; i < NUM_PAGES; i++) begin
				used_q[i] <= 1'b0;
				pcls_q[i] <= '0;
				pfc_q[i]  <= '0;
				fpq_q[i]  <= PGW'(i);
			end
			fq_hd_q  <= '0;
			fq_cnt_q <= NPW'(NUM_PAGES);
		end else if (reinit) begin
			for (int i = 0; i < NCLS; i++) begin
				head_q[i] <= LNULL;
				tail_q[i] <= LNULL;
			end
			for (int i = 0; i < NUM_PAGES; i++) begin
				used_q[i] <= 1'b0;
				pfc_q[i]  <= '0;
				fpq_q[i]  <= PGW'(i);
			end
			fq_hd_q  <= '0;
			fq_cnt_q <= cfg_pages;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= in_opcode;
						req_q  <= in_req_size;
						addr_q <= in_address;
					end
				end
				S_DEC: begin
					res_q    <= '0;
					cls_q    <= c_calc;
					pg_q     <= pg_calc;
					inside_q <= in_rgn;
					if (op_q == OP_ALLOC && too_big) res_q.status <= STAT_TOO_LARGE;
				end
				S_PG: begin
					if (!inside_q) begin
						res_q.status <= STAT_OUTSIDE;
					end else if (op_q == OP_QUERY) begin
						if (used_q[pg_q]) begin
							res_q.block_bytes <= 12'(32'(MIN_BLOCK_BYTES) << cls_pg);
						end
					end else if (!used_q[pg_q]) begin
						res_q.status <= STAT_OUTSIDE;
					end else begin
						cls_q  <= cls_pg;
						slot_q <= slot_f;
					end
				end
				S_F_CHK: mode_q <= M_FREE;
				S_A_CHK, S_SRCH: begin
					if (hd_nn) begin
						slot_q <= hd_sel;
						pg_q   <= PGW'(hd_sel >> SLW);
						mode_q <= M_POP;
					end else if (state_q == S_A_CHK && fq_cnt_q != '0) begin
						// carve the oldest free page into blocks of this class
						fq_hd_q    <= (32'(fq_hd_q) == NUM_PAGES - 1) ? '0 : fq_hd_q + 1'b1;
						fq_cnt_q   <= fq_cnt_q - 1'b1;
						used_q[np] <= 1'b1;
						pcls_q[np] <= cls_q;
						pfc_q[np]  <= total;
						pg_q       <= np;
						iter_q     <= '0;
						slot_q     <= LW'(np) << SLW;
						mode_q     <= M_CARVE;
					end else if (more_cls) begin
						cls_q <= cls_q + 1'b1;
					end else begin
						res_q.status <= STAT_NO_MEM;
					end
				end
				S_U1: begin
					if (pv_rdata == LNULL) head_q[cls_q] <= nx_rdata;
					if (nx_rdata == LNULL) tail_q[cls_q] <= pv_rdata;
				end
				S_U2: begin
					if (mode_q == M_POP) begin
						if (pfc_pg != '0) pfc_q[pg_q] <= pfc_pg - 1'b1;
						res_q.block_address <= region_base + (32'(slot_q) << MBW);
						res_q.block_bytes   <= 12'(32'(MIN_BLOCK_BYTES) << cls_q);
					end else if (last_blk) begin
						used_q[pg_q] <= 1'b0;
						pfc_q[pg_q]  <= '0;
						if (32'(fq_cnt_q) < NUM_PAGES) begin
							fpq_q[tl_idx] <= pg_q;
							fq_cnt_q      <= fq_cnt_q + 1'b1;
						end
					end else begin
						iter_q <= iter_q + 1'b1;
						slot_q <= slot_q + step;
					end
				end
				S_P0: begin
					t_q <= tail_q[cls_q];
					if (tail_q[cls_q] == LNULL) head_q[cls_q] <= slot_q;
					tail_q[cls_q] <= slot_q;
				end
				S_P1: begin
					if (mode_q == M_CARVE) begin
						if (!last_blk) begin
							iter_q <= iter_q + 1'b1;
							slot_q <= slot_q + step;
						end
					end else begin
						pfc_q[pg_q] <= PCW'(pfc_pg + 1'b1);
						if (new_full) begin
							mode_q <= M_REL;
							iter_q <= '0;
							slot_q <= LW'(pg_q) << SLW;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== design/page_slab_block_allocator.sv =====
`timescale 1ns / 1ps
// Allocation pops the head of a non-empty class; when the class is empty it carves
// the oldest free page into blocks of that class, else searches larger classes in turn.
// A free appends the block to its class; one that frees a whole page unlinks every block
// of that page and requeues it. One word is in the controller at a time.
// Reset (arst_n low, asynchronous): lists empty, all pages queued in ascending
// order, region_base 0, region_pages NUM_PAGES. No clearing pass is needed.
module page_slab_block_allocator import psba_pkg::*; #(
	parameter int NUM_PAGES       = 16,
	parameter int PAGE_BYTES      = 4096,
	parameter int MIN_BLOCK_BYTES = 8,
	parameter int MAX_BLOCK_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// request words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // opcode[1:0], req_size[13:2], address[45:14]
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // block_address[31:0], block_bytes[43:32], status[45:44]
);
	localparam int SLOTS = PAGE_BYTES / MIN_BLOCK_BYTES;
	localparam int NSLOT = NUM_PAGES * SLOTS;
	localparam int LW    = $clog2(NSLOT + 1);
	localparam int SAW   = (NSLOT > 1) ? $clog2(NSLOT) : 1;
	localparam int NPW   = $clog2(NUM_PAGES + 1);
	localparam int PBW   = $clog2(PAGE_BYTES);

	logic [31:0]    base_q;
	logic [NPW-1:0] pages_q;
	logic [NPW-1:0] pages_clamp;
	logic [4:0]     pages_raw;
	logic           reinit;

	result_t        res, out_q;
	logic           res_valid, res_ready, m_valid_q;

	logic [SAW-1:0] raddr, nx_waddr, pv_waddr;
	logic [LW-1:0]  nx_rdata, pv_rdata, nx_wdata, pv_wdata;
	logic           nx_we, pv_we;

	// region_pages write clamps cfg_data[4:0] to 1..NUM_PAGES and empties every list
	always_comb begin
		pages_raw = cfg_data[4:0];
		if (pages_raw == 5'd0) pages_clamp = NPW'(1);
		else if (32'(pages_raw) > NUM_PAGES) pages_clamp = NPW'(NUM_PAGES);
		else pages_clamp = NPW'(pages_raw);
	end
	assign reinit = cfg_we && cfg_index == CFG_REGION_PAGES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			pages_q <= NPW'(NUM_PAGES);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REGION_BASE:  base_q <= {cfg_data[31:PBW], PBW'(0)};
				CFG_REGION_PAGES: pages_q <= pages_clamp;
				default: ;
			endcase
		end
	end

	// output register: the next result is taken only while the register is empty or its word is being accepted
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			out_q     <= '0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
			out_q     <= res;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, out_q.status, out_q.block_bytes, out_q.block_address};

	psba_ctrl #(
		.NUM_PAGES(NUM_PAGES), .PAGE_BYTES(PAGE_BYTES),
		.MIN_BLOCK_BYTES(MIN_BLOCK_BYTES), .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.reinit(reinit), .cfg_pages(reinit ? pages_clamp : pages_q), .region_base(base_q),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_opcode(s_tdata[1:0]), .in_req_size(s_tdata[13:2]), .in_address(s_tdata[45:14]),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.raddr(raddr), .nx_rdata(nx_rdata), .pv_rdata(pv_rdata),
		.nx_we(nx_we), .nx_waddr(nx_waddr), .nx_wdata(nx_wdata),
		.pv_we(pv_we), .pv_waddr(pv_waddr), .pv_wdata(pv_wdata)
	);

	// forward and backward links of every minimum-size slot
	psba_ram #(.WIDTH(LW), .DEPTH(NSLOT)) u_next_ram (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.raddr(raddr), .rdata(nx_rdata)
	);

	psba_ram #(.WIDTH(LW), .DEPTH(NSLOT)) u_prev_ram (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.raddr(raddr), .rdata(pv_rdata)
	);
endmodule

// ===== dv/page_slab_block_allocator_tb.sv =====
`timescale 1ns / 1ps
module page_slab_block_allocator_tb;
	import psba_pkg::*;

	localparam int N_PAGES   = 16;
	localparam int PG_BYTES  = 4096;
	localparam int MIN_BLK   = 8;
	localparam int MAX_BLK   = 2048;
	localparam int SLOTS_PG  = PG_BYTES / MIN_BLK;   // 512 minimum blocks per page
	localparam int N_SLOTS   = N_PAGES * SLOTS_PG;
	localparam int NIL       = N_SLOTS;              // null link
	localparam int N_CLASSES = 9;                    // 8 .. 2048 bytes
	localparam logic [3:0] NO_CLASS = 4'hf;
	localparam int RAND_WORDS = 1330;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_REGION_BASE;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	page_slab_block_allocator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#200ms;
		$display("simulation failed");
		$finish;
	end

	// ---------------- allocator shadow state ----------------
	logic [31:0] sh_base;
	int          sh_pages;
	logic [3:0]  sh_page_class [N_PAGES];
	int          sh_page_free  [N_PAGES];
	int          sh_page_q     [N_PAGES];
	int          sh_page_q_cnt;
	int          sh_next [N_SLOTS];
	int          sh_prev [N_SLOTS];
	int          sh_head [N_CLASSES];
	int          sh_tail [N_CLASSES];

	// addresses the stimulus knows are currently handed out
	logic [31:0] live_blocks [$];

	result_t expected_results [$];
	int      mismatches = 0;
	int      outstanding = 0;

	function automatic void clear_lists();
		for (int i = 0; i < N_CLASSES; i++) begin
			sh_head[i] = NIL;
			sh_tail[i] = NIL;
		end
		for (int i = 0; i < N_SLOTS; i++) begin
			sh_next[i] = NIL;
			sh_prev[i] = NIL;
		end
		for (int i = 0; i < N_PAGES; i++) begin
			sh_page_class[i] = NO_CLASS;
			sh_page_free[i] = 0;
			sh_page_q[i] = i;
		end
		sh_page_q_cnt = sh_pages;
	endfunction

	function automatic void append_slot(int c, int s);
		int t;
		t = sh_tail[c];
		sh_next[s] = NIL;
		sh_prev[s] = t;
		if (t == NIL) sh_head[c] = s;
		else sh_next[t] = s;
		sh_tail[c] = s;
	endfunction

	function automatic void unlink_slot(int c, int s);
		int p, n;
		p = sh_prev[s];
		n = sh_next[s];
		if (p == NIL) sh_head[c] = n;
		else sh_next[p] = n;
		if (n == NIL) sh_tail[c] = p;
		else sh_prev[n] = p;
		sh_next[s] = NIL;
		sh_prev[s] = NIL;
	endfunction

	function automatic int pop_class(int c);
		int s, pg;
		s = sh_head[c];
		pg = s / SLOTS_PG;
		unlink_slot(c, s);
		if (sh_page_free[pg] > 0) sh_page_free[pg]--;
		return s;
	endfunction

	function automatic void apply_config(logic idx, logic [31:0] val);
		int v;
		if (idx == CFG_REGION_BASE) begin
			sh_base = val & ~(32'(PG_BYTES) - 1);
		end else begin
			v = int'(val[4:0]);
			if (v < 1) v = 1;
			if (v > N_PAGES) v = N_PAGES;
			sh_pages = v;
			clear_lists();
		end
	endfunction

	// works out the result word of one request and updates the shadow lists
	function automatic result_t allocator_result(logic [1:0] op, logic [11:0] req,
			logic [31:0] addr);
		result_t r;
		logic [31:0] offset;
		bit in_rgn;
		int pg, c, got, s, real_sz, np, stp, bs, total, blk;
		bit listed;
		r = '0;
		offset = addr - sh_base;
		in_rgn = longint'(offset) < longint'(sh_pages) * PG_BYTES;
		pg = offset / PG_BYTES;
		if (op == OP_ALLOC) begin
			if (req > MAX_BLK) begin
				r.status = STAT_TOO_LARGE;
			end else begin
				real_sz = MIN_BLK;
				c = 0;
				s = NIL;
				got = 0;
				while (real_sz < req && c + 1 < N_CLASSES) begin
					real_sz <<= 1;
					c++;
				end
				if (sh_head[c] != NIL) begin
					s = pop_class(c);
					got = c;
				end else if (sh_page_q_cnt > 0) begin
					np = sh_page_q[0] % N_PAGES;
					stp = real_sz / MIN_BLK;
					for (int i = 0; i < N_PAGES - 1; i++) sh_page_q[i] = sh_page_q[i + 1];
					sh_page_q_cnt--;
					sh_page_class[np] = 4'(c);
					sh_page_free[np] = PG_BYTES / real_sz;
					for (int i = 0; i < PG_BYTES / real_sz; i++)
						append_slot(c, np * SLOTS_PG + i * stp);
					s = pop_class(c);
					got = c;
				end else begin
					for (int k = c + 1; k < N_CLASSES; k++) begin
						if (sh_head[k] != NIL) begin
							s = pop_class(k);
							got = k;
							break;
						end
					end
				end
				if (s == NIL) begin
					r.status = STAT_NO_MEM;
				end else begin
					r.block_address = sh_base + (s / SLOTS_PG) * PG_BYTES
						+ (s % SLOTS_PG) * MIN_BLK;
					r.block_bytes = 12'(MIN_BLK << got);
				end
			end
		end else if (op == OP_FREE) begin
			if (!in_rgn || sh_page_class[pg] == NO_CLASS) begin
				r.status = STAT_OUTSIDE;
			end else begin
				c = int'(sh_page_class[pg]);
				bs = MIN_BLK << c;
				stp = bs / MIN_BLK;
				total = PG_BYTES / bs;
				blk = (offset % PG_BYTES) / bs;
				s = pg * SLOTS_PG + blk * stp;
				listed = sh_prev[s] != NIL || sh_head[c] == s;
				if (!listed && sh_page_free[pg] < total) begin
					append_slot(c, s);
					sh_page_free[pg]++;
					if (sh_page_free[pg] == total) begin
						for (int i = 0; i < total; i++) unlink_slot(c, pg * SLOTS_PG + i * stp);
						sh_page_class[pg] = NO_CLASS;
						sh_page_free[pg] = 0;
						if (sh_page_q_cnt < N_PAGES) sh_page_q[sh_page_q_cnt++] = pg;
					end
				end
			end
		end else if (op == OP_QUERY) begin
			if (!in_rgn) r.status = STAT_OUTSIDE;
			else if (sh_page_class[pg] != NO_CLASS) r.block_bytes = 12'(MIN_BLK << sh_page_class[pg]);
		end
		return r;
	endfunction

	// ---------------- driving ----------------
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	bit quiet_phase = 1'b0;

	// one request word; hands back when accepted. When typed is set the row's
	// own expected result is checked against the predictor as well.
	task automatic send_word(logic [1:0] op, logic [11:0] req, logic [31:0] addr,
			bit typed = 1'b0, result_t known = '0);
		result_t r;
		int g;
		g = quiet_phase ? 0 : gap_len();
		// valid drops on the falling edge after an accept
		repeat (g + 1) @(negedge clk);
		s_tdata <= {2'b0, addr, req, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = allocator_result(op, req, addr);
		if (typed && r !== known) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row mismatch: op %0d req %0d addr %h exp %h got %h",
					op, req, addr, known, r);
		end
		if (op == OP_ALLOC && r.status == STAT_OK) live_blocks.push_back(r.block_address);
		expected_results.push_back(r);
		outstanding++;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (outstanding != 0) @(negedge clk);
		repeat (4000) @(negedge clk);   // a full page release is the slow path
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_config(idx, val);
		if (idx == CFG_REGION_PAGES) live_blocks.delete();
	endtask

	// ---------------- result side ----------------
	always begin
		int g;
		@(negedge clk);
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			g = gap_len();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
		m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		result_t got, exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[45:0];
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
			end else begin
				exp_r = expected_results.pop_front();
				outstanding--;
				if (got.block_address !== exp_r.block_address
						|| got.block_bytes !== exp_r.block_bytes
						|| got.status !== exp_r.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp addr %h bytes %0d status %0d, got addr %h bytes %0d status %0d",
							exp_r.block_address, exp_r.block_bytes, exp_r.status,
							got.block_address, got.block_bytes, got.status);
				end
			end
		end
	end

	// ---------------- directed table ----------------
	typedef struct {
		logic [1:0]  op;
		logic [11:0] req;
		logic [31:0] addr;
		bit          typed;
		result_t     known;
	} stim_row_t;

	stim_row_t dir_rows [] = '{
		// first alloc after reset carves page 0 into 8-byte blocks
		'{OP_ALLOC, 12'd0,    32'h0,        1'b1, '{STAT_OK, 12'd8, 32'h0}},
		'{OP_ALLOC, 12'd1,    32'h0,        1'b1, '{STAT_OK, 12'd8, 32'h8}},
		'{OP_ALLOC, 12'd2048, 32'h0,        1'b1, '{STAT_OK, 12'd2048, 32'h1000}},
		'{OP_ALLOC, 12'd2049, 32'h0,        1'b1, '{STAT_TOO_LARGE, 12'd0, 32'h0}},
		'{OP_ALLOC, 12'hfff,  32'h0,        1'b1, '{STAT_TOO_LARGE, 12'd0, 32'h0}},
		'{OP_ALLOC, 12'd9,    32'h0,        1'b0, '0},
		'{OP_ALLOC, 12'd100,  32'h0,        1'b0, '0},
		'{OP_QUERY, 12'd0,    32'h0,        1'b1, '{STAT_OK, 12'd8, 32'h0}},
		'{OP_QUERY, 12'd0,    32'h1004,     1'b1, '{STAT_OK, 12'd2048, 32'h0}},
		'{OP_QUERY, 12'd0,    32'hffff_ffff, 1'b1, '{STAT_OUTSIDE, 12'd0, 32'h0}},
		'{OP_QUERY, 12'd0,    32'h0000_f000, 1'b1, '{STAT_OK, 12'd0, 32'h0}},
		'{OP_FREE,  12'd0,    32'h0001_0000, 1'b1, '{STAT_OUTSIDE, 12'd0, 32'h0}},
		'{OP_FREE,  12'd0,    32'h0000_e000, 1'b1, '{STAT_OUTSIDE, 12'd0, 32'h0}},
		'{OP_FREE,  12'd0,    32'h0000_000c, 1'b0, '0},   // unaligned, frees the block at 8
		'{OP_FREE,  12'd0,    32'h0000_0008, 1'b0, '0},   // double free
		'{OP_FREE,  12'd0,    32'h0000_1001, 1'b0, '0},   // releases whole page
		'{OP_QUERY, 12'd0,    32'h0000_1000, 1'b0, '0},
		'{2'd3,     12'hfff,  32'hffff_ffff, 1'b1, '{STAT_OK, 12'd0, 32'h0}},
		'{OP_FREE,  12'hfff,  32'h0,        1'b0, '0},
		'{OP_FREE,  12'd0,    32'h0,        1'b0, '0}
	};

	// ---------------- random part ----------------
	task automatic random_word();
		int p, k;
		logic [11:0] req;
		logic [31:0] a;
		p = $urandom_range(0, 99);
		if (p < 50) begin
			k = $urandom_range(0, 99);
			if (k < 70) req = 12'($urandom_range(0, 64));
			else if (k < 95) req = 12'($urandom_range(0, MAX_BLK));
			else req = 12'($urandom());
			send_word(OP_ALLOC, req, $urandom());
		end else if (p < 85 && live_blocks.size() > 0) begin
			k = $urandom_range(0, live_blocks.size() - 1);
			a = live_blocks[k];
			live_blocks.delete(k);
			if ($urandom_range(0, 7) == 0) a += $urandom_range(0, 7);
			send_word(OP_FREE, 12'($urandom()), a);
		end else if (p < 93) begin
			a = sh_base + $urandom_range(0, N_PAGES * PG_BYTES + 4096);
			send_word($urandom_range(0, 9) < 7 ? OP_QUERY : OP_FREE, 12'($urandom()), a);
		end else begin
			send_word(2'($urandom()), 12'($urandom()), $urandom());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		sh_base = '0;
		sh_pages = N_PAGES;
		clear_lists();

		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].req, dir_rows[i].addr,
				dir_rows[i].typed, dir_rows[i].known);

		// region settings, extremes included; base low bits must be dropped
		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			case (ph)
				0: begin write_reg(CFG_REGION_BASE, 32'hffff_f000); write_reg(CFG_REGION_PAGES, 32'd1); end
				1: begin write_reg(CFG_REGION_BASE, 32'h1234_5abc); write_reg(CFG_REGION_PAGES, 32'd3); end
				2: begin write_reg(CFG_REGION_BASE, 32'hffff_ffff); write_reg(CFG_REGION_PAGES, 32'd0); end
				3: begin write_reg(CFG_REGION_BASE, $urandom()); write_reg(CFG_REGION_PAGES, 32'hffff_ffff); end
				4: begin write_reg(CFG_REGION_BASE, 32'h0); write_reg(CFG_REGION_PAGES, 32'd16); end
				default: begin write_reg(CFG_REGION_BASE, $urandom()); write_reg(CFG_REGION_PAGES, $urandom_range(2, 8)); end
			endcase
			quiet_phase = (ph == 4);
			for (int n = 0; n < RAND_WORDS / 6; n++) begin
				// at word 100 the sender holds off until the block has answered everything
				if (n == 100) while (outstanding != 0) @(negedge clk);
				random_word();
			end
			quiet_phase = 1'b0;
		end

		wait_drained();
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
